// File: src/imu_rate_integrate_and_tilt_defines.svh
// Assertion macros used by the checker file of the IMU block.
`ifndef IMU_RATE_INTEGRATE_AND_TILT_DEFINES_SVH
`define IMU_RATE_INTEGRATE_AND_TILT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define IRT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define IRT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// Shared types, codes, defaults and the arctangent table of the IMU block.
// ----------------------------------------------------------------------------
`default_nettype none

package irt_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_FRAC_DEF   = 8;
  localparam int TAB_LEN          = 24;
  localparam int TAB_IW           = 5;

  localparam logic [1:0] ACT_GYRO  = 2'd0;
  localparam logic [1:0] ACT_ACCEL = 2'd1;
  localparam logic [1:0] ACT_GCAL  = 2'd2;
  localparam logic [1:0] ACT_ACAL  = 2'd3;

  localparam logic [2:0] REG_GYRO_CAL  = 3'd0;
  localparam logic [2:0] REG_ACC_CAL   = 3'd1;
  localparam logic [2:0] REG_STEP_TIME = 3'd2;
  localparam logic [2:0] REG_INV_ROLL  = 3'd3;
  localparam logic [2:0] REG_INV_PITCH = 3'd4;
  localparam logic [2:0] REG_INV_YAW   = 3'd5;

  localparam logic [15:0] GYRO_CAL_DEF  = 16'd256;
  localparam logic [15:0] ACC_CAL_DEF   = 16'd256;
  localparam logic [15:0] STEP_TIME_DEF = 16'd66;
  localparam logic [15:0] INV_ROLL_DEF  = 16'd986;
  localparam logic [15:0] INV_PITCH_DEF = 16'd986;
  localparam logic [15:0] INV_YAW_DEF   = 16'd1001;

  typedef struct packed {
    logic start;
    logic ack;
  } lane_ctl_t;

  typedef enum logic [2:0] {
    AX_IDLE, AX_RATE, AX_MUL2, AX_INT, AX_DIV, AX_DONE
  } ax_state_t;

  typedef enum logic [2:0] {
    TL_IDLE, TL_SQ, TL_SUM, TL_ROOT, TL_ROT, TL_FIN, TL_DONE
  } tl_state_t;

  typedef enum logic {
    TOP_IDLE, TOP_RUN
  } top_state_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_entry(input logic [TAB_IW-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/imu_rate_integrate_and_tilt.sv
// ----------------------------------------------------------------------------
// imu_rate_integrate_and_tilt
// Gyro rate integration, accelerometer tilt and sensor offset calibration.
// ----------------------------------------------------------------------------
// Usage: present one sample beat on in_* with in_valid; it is taken when
// in_stall is low. Each beat gives exactly one result beat on out_*, held
// while out_stall is high. Registers are written through cfg_we/cfg_index/
// cfg_data while no item is in flight.
// One item is worked on at a time; in_stall is high from acceptance until
// the result is loaded into the output register, which may still be waiting
// on the receiver while the next item is taken.
// Work per item, accept to result register:
//   gyro measurement  two multiplies with a rounding stage between them
//   accel measurement 17-step square root, then CORDIC
//   calibration       sum update; bit-serial divide when the run completes
// The three axis lanes and two tilt lanes run side by side; the result is
// loaded once every lane has finished the item.
// Reset restores register defaults and clears offsets, sums, angles and
// tilts; the block takes an item in the cycle after reset is released.
// A stalled receiver holds the result; a finished item waits in its lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_rate_integrate_and_tilt #(
  parameter int CORDIC_STEPS    = irt_pkg::CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = irt_pkg::ANGLE_FRAC_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [1:0]         in_action,
  input  wire  signed [15:0] in_x_raw,
  input  wire  signed [15:0] in_y_raw,
  input  wire  signed [15:0] in_z_raw,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [1:0]         out_kind,
  output logic signed [24:0] out_rate_roll,
  output logic signed [24:0] out_rate_pitch,
  output logic signed [24:0] out_rate_yaw,
  output logic signed [31:0] out_angle_roll,
  output logic signed [31:0] out_angle_pitch,
  output logic signed [31:0] out_angle_yaw,
  output logic signed [15:0] out_tilt_roll,
  output logic signed [15:0] out_tilt_pitch,
  output logic               out_cal_done,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_index,
  input  wire  [15:0]        cfg_data
);
  import irt_pkg::*;

  top_state_t state_r, state_nxt;
  logic [15:0] gyro_cal_r, acc_cal_r, step_time_r;
  logic [15:0] inv_sens_r [3];
  logic [15:0] cal_cnt_r;
  logic [1:0]  act_r;
  logic        cal_done_r;
  logic        out_valid_r;

  logic [1:0]         o_kind_r;
  logic signed [24:0] o_rate_r  [3];
  logic signed [31:0] o_angle_r [3];
  logic signed [15:0] o_tilt_r  [2];
  logic               o_cal_r;

  logic               accept, load, all_done, is_cal;
  logic [15:0]        need, need1;
  logic [16:0]        n_cnt;
  logic               complete;
  lane_ctl_t          ctl;
  logic signed [15:0] raw_in   [3];
  logic               ax_done  [3];
  logic signed [24:0] ax_rate  [3];
  logic signed [31:0] ax_angle [3];
  logic signed [15:0] ax_aoff  [3];
  logic               tl_done  [2];
  logic signed [15:0] tl_tilt  [2];
  logic signed [16:0] acc_x, acc_y, acc_z, neg_x;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != TOP_IDLE);
  assign is_cal   = (in_action == ACT_GCAL) || (in_action == ACT_ACAL);
  assign need     = (in_action == ACT_GCAL) ? gyro_cal_r : acc_cal_r;
  assign need1    = (need == 16'd0) ? 16'd1 : need;
  assign n_cnt    = {1'b0, cal_cnt_r} + 17'd1;
  assign complete = (n_cnt >= {1'b0, need1});

  assign raw_in[0] = in_x_raw;
  assign raw_in[1] = in_y_raw;
  assign raw_in[2] = in_z_raw;

  assign acc_x = 17'(in_x_raw) - 17'(ax_aoff[0]);
  assign acc_y = 17'(in_y_raw) - 17'(ax_aoff[1]);
  assign acc_z = 17'(in_z_raw);
  assign neg_x = -acc_x;

  assign all_done = ax_done[0] && ax_done[1] && ax_done[2] && tl_done[0] && tl_done[1];
  assign load     = (state_r == TOP_RUN) && all_done && (!out_valid_r || !out_stall);

  assign ctl.start = accept;
  assign ctl.ack   = load;

  for (genvar g = 0; g < 3; g++) begin : g_axis
    irt_axis_lane #(
      .FRAC(ANGLE_FRAC_BITS)
    ) u_axis (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .action   (in_action),
      .raw      (raw_in[g]),
      .inv_sens (inv_sens_r[g]),
      .step_time(step_time_r),
      .divisor  (n_cnt[15:0]),
      .complete (complete),
      .done     (ax_done[g]),
      .rate     (ax_rate[g]),
      .angle    (ax_angle[g]),
      .acc_off  (ax_aoff[g])
    );
  end

  irt_tilt_lane #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .FRAC        (ANGLE_FRAC_BITS)
  ) u_tilt_roll (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .en   (in_action == ACT_ACCEL),
    .num  (acc_y),
    .a    (acc_x),
    .b    (acc_z),
    .done (tl_done[0]),
    .tilt (tl_tilt[0])
  );

  irt_tilt_lane #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .FRAC        (ANGLE_FRAC_BITS)
  ) u_tilt_pitch (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .en   (in_action == ACT_ACCEL),
    .num  (neg_x),
    .a    (acc_y),
    .b    (acc_z),
    .done (tl_done[1]),
    .tilt (tl_tilt[1])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= TOP_IDLE;
      gyro_cal_r    <= GYRO_CAL_DEF;
      acc_cal_r     <= ACC_CAL_DEF;
      step_time_r   <= STEP_TIME_DEF;
      inv_sens_r[0] <= INV_ROLL_DEF;
      inv_sens_r[1] <= INV_PITCH_DEF;
      inv_sens_r[2] <= INV_YAW_DEF;
      cal_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_GYRO_CAL:  gyro_cal_r    <= cfg_data;
          REG_ACC_CAL:   acc_cal_r     <= cfg_data;
          REG_STEP_TIME: step_time_r   <= cfg_data;
          REG_INV_ROLL:  inv_sens_r[0] <= cfg_data;
          REG_INV_PITCH: inv_sens_r[1] <= cfg_data;
          REG_INV_YAW:   inv_sens_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (accept && is_cal) begin
        cal_cnt_r <= complete ? 16'd0 : n_cnt[15:0];
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item tag and merged result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r      <= in_action;
      cal_done_r <= is_cal && complete;
    end
    if (load) begin
      o_kind_r <= act_r;
      for (int k = 0; k < 3; k++) begin
        o_rate_r[k]  <= (act_r == ACT_GYRO) ? ax_rate[k] : 25'sd0;
        o_angle_r[k] <= ax_angle[k];
      end
      o_tilt_r[0] <= tl_tilt[0];
      o_tilt_r[1] <= tl_tilt[1];
      o_cal_r     <= cal_done_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TOP_IDLE: if (accept) state_nxt = TOP_RUN;
      TOP_RUN:  if (load) state_nxt = TOP_IDLE;
      default:  state_nxt = TOP_IDLE;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = o_kind_r;
  assign out_rate_roll   = o_rate_r[0];
  assign out_rate_pitch  = o_rate_r[1];
  assign out_rate_yaw    = o_rate_r[2];
  assign out_angle_roll  = o_angle_r[0];
  assign out_angle_pitch = o_angle_r[1];
  assign out_angle_yaw   = o_angle_r[2];
  assign out_tilt_roll   = o_tilt_r[0];
  assign out_tilt_pitch  = o_tilt_r[1];
  assign out_cal_done    = o_cal_r;

endmodule

`default_nettype wire

// File: src/irt_axis_lane.sv
// ----------------------------------------------------------------------------
// irt_axis_lane
// One axis: gyro rate and angle integration, calibration sum and offset divide.
// ----------------------------------------------------------------------------
`default_nettype none

module irt_axis_lane #(
  parameter int FRAC = irt_pkg::ANGLE_FRAC_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  irt_pkg::lane_ctl_t       ctl,
  input  wire  [1:0]               action,
  input  wire  signed [15:0]       raw,
  input  wire  [15:0]              inv_sens,
  input  wire  [15:0]              step_time,
  input  wire  [15:0]              divisor,
  input  wire                      complete,
  output logic                     done,
  output logic signed [24:0]       rate,
  output logic signed [31:0]       angle,
  output logic signed [15:0]       acc_off
);
  import irt_pkg::*;

  localparam int SH = 16 - FRAC;
  localparam logic signed [33:0] HALF1 = 34'sd1 <<< (SH - 1);
  localparam logic signed [41:0] HALF2 = 42'sd32768;
  localparam logic [5:0] DIV_LAST = 6'd32;

  ax_state_t state_r, state_nxt;
  logic signed [15:0] gyro_off_r, gyro_off_nxt;
  logic signed [15:0] acc_off_r, acc_off_nxt;
  logic signed [32:0] sum_r, sum_nxt;
  logic signed [31:0] angle_r, angle_nxt;
  logic signed [24:0] rate_r, rate_nxt;
  logic signed [33:0] prod1_r, prod1_nxt;
  logic signed [41:0] prod2_r, prod2_nxt;
  logic [32:0] quo_r, quo_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] div_r, div_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic        tgt_gyro_r, tgt_gyro_nxt;

  logic signed [16:0] d;
  logic signed [32:0] sum_add;
  logic signed [33:0] rnd;
  logic signed [41:0] inc_full;
  logic signed [33:0] acc_sum;
  logic [16:0] shifted;
  logic        ge;
  logic [15:0] off_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= AX_IDLE;
      gyro_off_r <= '0;
      acc_off_r  <= '0;
      sum_r      <= '0;
      angle_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      gyro_off_r <= gyro_off_nxt;
      acc_off_r  <= acc_off_nxt;
      sum_r      <= sum_nxt;
      angle_r    <= angle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rate_r     <= rate_nxt;
    prod1_r    <= prod1_nxt;
    prod2_r    <= prod2_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    tgt_gyro_r <= tgt_gyro_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    gyro_off_nxt = gyro_off_r;
    acc_off_nxt  = acc_off_r;
    sum_nxt      = sum_r;
    angle_nxt    = angle_r;
    rate_nxt     = rate_r;
    prod1_nxt    = prod1_r;
    prod2_nxt    = prod2_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    div_nxt      = div_r;
    cnt_nxt      = cnt_r;
    neg_nxt      = neg_r;
    tgt_gyro_nxt = tgt_gyro_r;

    d        = 17'(raw) - 17'(gyro_off_r);
    sum_add  = sum_r + 33'(raw);
    rnd      = (prod1_r + HALF1) >>> SH;
    inc_full = (prod2_r + HALF2) >>> 16;
    acc_sum  = 34'(angle_r) + 34'($signed(inc_full[25:0]));
    shifted  = {rem_r, quo_r[32]};
    ge       = shifted >= {1'b0, div_r};
    off_mag  = 16'd0;

    case (state_r)
      AX_IDLE: begin
        if (ctl.start) begin
          case (action)
            ACT_GYRO: begin
              prod1_nxt = 34'(d) * $signed({18'd0, inv_sens});
              state_nxt = AX_RATE;
            end
            ACT_ACCEL: state_nxt = AX_DONE;
            default: begin
              if (complete) begin
                neg_nxt      = sum_add[32];
                quo_nxt      = sum_add[32] ? 33'(-sum_add) : 33'(sum_add);
                rem_nxt      = '0;
                div_nxt      = divisor;
                cnt_nxt      = '0;
                tgt_gyro_nxt = (action == ACT_GCAL);
                sum_nxt      = '0;
                state_nxt    = AX_DIV;
              end else begin
                sum_nxt   = sum_add;
                state_nxt = AX_DONE;
              end
            end
          endcase
        end
      end
      AX_RATE: begin
        if (rnd > 34'sd16777215) begin
          rate_nxt = 25'sh0FFFFFF;
        end else if (rnd < -34'sd16777216) begin
          rate_nxt = 25'sh1000000;
        end else begin
          rate_nxt = rnd[24:0];
        end
        state_nxt = AX_MUL2;
      end
      AX_MUL2: begin
        prod2_nxt = 42'(rate_r) * $signed({26'd0, step_time});
        state_nxt = AX_INT;
      end
      AX_INT: begin
        if (acc_sum > 34'sd2147483647) begin
          angle_nxt = 32'sh7FFFFFFF;
        end else if (acc_sum < -34'sd2147483648) begin
          angle_nxt = 32'sh80000000;
        end else begin
          angle_nxt = acc_sum[31:0];
        end
        state_nxt = AX_DONE;
      end
      AX_DIV: begin
        rem_nxt = ge ? 16'(shifted - {1'b0, div_r}) : shifted[15:0];
        quo_nxt = {quo_r[31:0], ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          off_mag = neg_r ? 16'(-quo_nxt[15:0]) : quo_nxt[15:0];
          if (tgt_gyro_r) begin
            gyro_off_nxt = off_mag;
          end else begin
            acc_off_nxt = off_mag;
          end
          state_nxt = AX_DONE;
        end
      end
      AX_DONE: begin
        if (ctl.ack) state_nxt = AX_IDLE;
      end
      default: state_nxt = AX_IDLE;
    endcase
  end

  assign done    = (state_r == AX_DONE);
  assign rate    = rate_r;
  assign angle   = angle_r;
  assign acc_off = acc_off_r;

endmodule

`default_nettype wire

// File: src/irt_tilt_lane.sv
// ----------------------------------------------------------------------------
// irt_tilt_lane
// One tilt angle: integer square root of a sum of squares, then a CORDIC atan.
// ----------------------------------------------------------------------------
`default_nettype none

module irt_tilt_lane #(
  parameter int CORDIC_STEPS = irt_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC         = irt_pkg::ANGLE_FRAC_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  irt_pkg::lane_ctl_t   ctl,
  input  wire                  en,
  input  wire  signed [16:0]   num,
  input  wire  signed [16:0]   a,
  input  wire  signed [16:0]   b,
  output logic                 done,
  output logic signed [15:0]   tilt
);
  import irt_pkg::*;

  localparam int SH      = 16 - FRAC;
  localparam int LIM_RAW = 90 << FRAC;
  localparam int LIM     = (LIM_RAW > 32767) ? 32767 : LIM_RAW;
  localparam logic signed [25:0] LIM_P = 26'(LIM);
  localparam logic signed [25:0] LIM_N = -26'(LIM);
  localparam logic signed [25:0] HALF  = 26'sd1 <<< (SH - 1);
  localparam logic [TAB_IW-1:0] STEP_LAST = TAB_IW'(CORDIC_STEPS - 1);
  localparam logic [33:0] BIT_TOP = 34'd1 << 32;

  tl_state_t state_r, state_nxt;
  logic signed [15:0] tilt_r, tilt_nxt;
  logic signed [16:0] num_r, num_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [33:0] asq_r, asq_nxt, bsq_r, bsq_nxt;
  logic [33:0] v_r, v_nxt, rt_r, rt_nxt, bit_r, bit_nxt;
  logic signed [29:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [24:0] z_r, z_nxt;
  logic [TAB_IW-1:0] i_r, i_nxt;

  logic [33:0] trial;
  logic signed [29:0] xs, ys;
  logic signed [24:0] ang;
  logic signed [25:0] zr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TL_IDLE;
      tilt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      tilt_r  <= tilt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    asq_r <= asq_nxt;
    bsq_r <= bsq_nxt;
    v_r   <= v_nxt;
    rt_r  <= rt_nxt;
    bit_r <= bit_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    i_r   <= i_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    tilt_nxt  = tilt_r;
    num_nxt   = num_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    asq_nxt   = asq_r;
    bsq_nxt   = bsq_r;
    v_nxt     = v_r;
    rt_nxt    = rt_r;
    bit_nxt   = bit_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    i_nxt     = i_r;

    trial = rt_r + bit_r;
    xs    = x_r >>> i_r;
    ys    = y_r >>> i_r;
    ang   = 25'(atan_entry(i_r));
    zr    = (26'(z_r) + HALF) >>> SH;

    case (state_r)
      TL_IDLE: begin
        if (ctl.start) begin
          if (!en) begin
            state_nxt = TL_DONE;
          end else if (num == 17'sd0) begin
            tilt_nxt  = '0;
            state_nxt = TL_DONE;
          end else begin
            num_nxt   = num;
            a_nxt     = a;
            b_nxt     = b;
            state_nxt = TL_SQ;
          end
        end
      end
      TL_SQ: begin
        asq_nxt   = 34'(a_r * a_r);
        bsq_nxt   = 34'(b_r * b_r);
        state_nxt = TL_SUM;
      end
      TL_SUM: begin
        v_nxt     = asq_r + bsq_r;
        rt_nxt    = '0;
        bit_nxt   = BIT_TOP;
        state_nxt = TL_ROOT;
      end
      TL_ROOT: begin
        if (v_r >= trial) begin
          v_nxt  = v_r - trial;
          rt_nxt = (rt_r >> 1) + bit_r;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == 34'd1) begin
          x_nxt     = $signed({5'd0, rt_nxt[16:0], 8'd0});
          y_nxt     = $signed({{5{num_r[16]}}, num_r, 8'd0});
          z_nxt     = '0;
          i_nxt     = '0;
          state_nxt = TL_ROT;
        end
      end
      TL_ROT: begin
        // rotate towards y = 0, accumulating the angle turned
        if (!y_r[29]) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + ang;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - ang;
        end
        i_nxt = i_r + 1'b1;
        if (i_r == STEP_LAST) state_nxt = TL_FIN;
      end
      TL_FIN: begin
        if (zr > LIM_P) begin
          tilt_nxt = LIM_P[15:0];
        end else if (zr < LIM_N) begin
          tilt_nxt = LIM_N[15:0];
        end else begin
          tilt_nxt = zr[15:0];
        end
        state_nxt = TL_DONE;
      end
      TL_DONE: begin
        if (ctl.ack) state_nxt = TL_IDLE;
      end
      default: state_nxt = TL_IDLE;
    endcase
  end

  assign done = (state_r == TL_DONE);
  assign tilt = tilt_r;

endmodule

`default_nettype wire

// File: src/irt_checker.sv
// ----------------------------------------------------------------------------
// irt_checker
// Port-level checks of the IMU block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "imu_rate_integrate_and_tilt_defines.svh"

module irt_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_stall,
  input wire               out_valid,
  input wire               out_stall,
  input wire [1:0]         out_kind,
  input wire signed [24:0] out_rate_roll,
  input wire signed [24:0] out_rate_pitch,
  input wire signed [24:0] out_rate_yaw,
  input wire signed [31:0] out_angle_roll,
  input wire signed [15:0] out_tilt_roll,
  input wire               out_cal_done
);
  import irt_pkg::*;

  `IRT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result beat dropped")
  `IRT_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_angle_roll) && $stable(out_tilt_roll) && $stable(out_kind), "stalled beat changed")
  `IRT_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken while busy")
  `IRT_ASSERT_IMP(a_rate_zero, clk, rst_n, out_valid && (out_kind != ACT_GYRO), (out_rate_roll == 25'sd0) && (out_rate_pitch == 25'sd0) && (out_rate_yaw == 25'sd0), "rate on non-gyro beat")
  `IRT_ASSERT_IMP(a_cal_kind, clk, rst_n, out_valid && out_cal_done, (out_kind == ACT_GCAL) || (out_kind == ACT_ACAL), "calibration done on measurement")

endmodule

bind imu_rate_integrate_and_tilt irt_checker u_irt_checker (.*);

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IMU rate integration and tilt block: drives
// directed and random sample beats with random gaps and receiver stalls, and
// checks every result beat field by field against a behavioural predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import irt_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 60;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [24:0] rate_roll;
    logic signed [24:0] rate_pitch;
    logic signed [24:0] rate_yaw;
    logic signed [31:0] angle_roll;
    logic signed [31:0] angle_pitch;
    logic signed [31:0] angle_yaw;
    logic signed [15:0] tilt_roll;
    logic signed [15:0] tilt_pitch;
    logic               cal_done;
  } imu_result_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               typed;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = ACT_GYRO;
  logic signed [15:0] in_x_raw = '0, in_y_raw = '0, in_z_raw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_kind;
  logic signed [24:0] out_rate_roll, out_rate_pitch, out_rate_yaw;
  logic signed [31:0] out_angle_roll, out_angle_pitch, out_angle_yaw;
  logic signed [15:0] out_tilt_roll, out_tilt_pitch;
  logic out_cal_done;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_GYRO_CAL;
  logic [15:0] cfg_data = '0;

  always #6 clk = ~clk;

  imu_rate_integrate_and_tilt i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_x_raw(in_x_raw), .in_y_raw(in_y_raw), .in_z_raw(in_z_raw),
    .out_valid(out_valid), .out_stall(out_stall), .out_kind(out_kind),
    .out_rate_roll(out_rate_roll), .out_rate_pitch(out_rate_pitch),
    .out_rate_yaw(out_rate_yaw), .out_angle_roll(out_angle_roll),
    .out_angle_pitch(out_angle_pitch), .out_angle_yaw(out_angle_yaw),
    .out_tilt_roll(out_tilt_roll), .out_tilt_pitch(out_tilt_pitch),
    .out_cal_done(out_cal_done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state and register copies
  logic [15:0] gyro_cnt_reg, acc_cnt_reg, step_reg;
  logic [15:0] inv_reg [3];
  longint gyro_off [3], acc_off [3], sums [3], angles [3];
  longint cal_count;
  longint tilts [2];

  longint atan_lut [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                            58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                            229, 115};

  imu_result_t pending_results [$];
  int errors = 0;
  int sent_by_kind [4] = '{0, 0, 0, 0};
  int got_results = 0;
  int cal_completions = 0;
  int rate_clamps = 0;
  bit calm = 1'b0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint int_root(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan(num / sqrt(a^2 + b^2)) in 1/256 degree
  function automatic longint cordic_tilt(longint num, longint a, longint b);
    longint cx, cy, cz, xs, ys;
    cz = 0;
    if (num == 0) return 0;
    cx = int_root(a * a + b * b) * 256;
    cy = num * 256;
    for (int i = 0; i < 16; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx = cx + ys; cy = cy - xs; cz = cz + atan_lut[i];
      end else begin
        cx = cx - ys; cy = cy + xs; cz = cz - atan_lut[i];
      end
    end
    return clip(round_half_up(cz, 8), -23040, 23040);
  endfunction

  function automatic imu_result_t predict_sample(logic [1:0] act, logic signed [15:0] xr,
                                                 logic signed [15:0] yr,
                                                 logic signed [15:0] zr);
    imu_result_t res;
    longint raw [3];
    longint rate [3];
    longint need, n, d, xa, ya;
    raw[0] = xr; raw[1] = yr; raw[2] = zr;
    rate = '{0, 0, 0};
    res = '0;
    if (act == ACT_GYRO) begin
      for (int i = 0; i < 3; i++) begin
        d = raw[i] - gyro_off[i];
        rate[i] = round_half_up(d * longint'(inv_reg[i]), 8);
        if (rate[i] > 16777215 || rate[i] < -16777216) rate_clamps++;
        rate[i] = clip(rate[i], -16777216, 16777215);
        angles[i] = clip(angles[i] + round_half_up(rate[i] * longint'(step_reg), 16),
                         -64'sd2147483648, 64'sd2147483647);
      end
    end else if (act == ACT_ACCEL) begin
      xa = raw[0] - acc_off[0];
      ya = raw[1] - acc_off[1];
      tilts[0] = cordic_tilt(ya, xa, raw[2]);
      tilts[1] = cordic_tilt(-xa, ya, raw[2]);
    end else begin
      need = (act == ACT_GCAL) ? gyro_cnt_reg : acc_cnt_reg;
      if (need == 0) need = 1;
      n = cal_count + 1;
      for (int i = 0; i < 3; i++) sums[i] = sums[i] + raw[i];
      if (n >= need) begin
        for (int i = 0; i < 3; i++) begin
          // truncate toward zero, then keep the low word
          d = longint'(16'(sums[i] / n));
          d = (d >= 32768) ? d - 65536 : d;
          if (act == ACT_GCAL) gyro_off[i] = d;
          else acc_off[i] = d;
          sums[i] = 0;
        end
        cal_count = 0;
        res.cal_done = 1'b1;
      end else begin
        cal_count = n;
      end
    end
    res.kind = act;
    res.rate_roll = 25'(rate[0]);
    res.rate_pitch = 25'(rate[1]);
    res.rate_yaw = 25'(rate[2]);
    res.angle_roll = 32'(angles[0]);
    res.angle_pitch = 32'(angles[1]);
    res.angle_yaw = 32'(angles[2]);
    res.tilt_roll = 16'(tilts[0]);
    res.tilt_pitch = 16'(tilts[1]);
    return res;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Result side: random receiver stalls, compare, watchdog
  int stall_left = 0;
  int idle_cycles = 0;
  imu_result_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got_results++;
        if (pending_results.size() == 0) begin
          $error("result beat with no expectation waiting, kind %0d", out_kind);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("rate_roll", want.rate_roll, out_rate_roll);
          check_field("rate_pitch", want.rate_pitch, out_rate_pitch);
          check_field("rate_yaw", want.rate_yaw, out_rate_yaw);
          check_field("angle_roll", want.angle_roll, out_angle_roll);
          check_field("angle_pitch", want.angle_pitch, out_angle_pitch);
          check_field("angle_yaw", want.angle_yaw, out_angle_yaw);
          check_field("tilt_roll", want.tilt_roll, out_tilt_roll);
          check_field("tilt_pitch", want.tilt_pitch, out_tilt_pitch);
          check_field("cal_done", want.cal_done, out_cal_done);
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
      // stall bursts: mostly short, a few long, no new burst while calm
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else if (calm || $urandom_range(0, 99) < 55) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 50)
                                                 : $urandom_range(0, 3);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 45);
  endfunction

  task automatic send_sample(logic [1:0] act, logic signed [15:0] xr,
                             logic signed [15:0] yr, logic signed [15:0] zr,
                             bit typed);
    int gap;
    imu_result_t exp_res;
    gap = pick_gap();
    if ($urandom_range(0, 59) == 0) calm = ~calm;
    if (gap > 0 && in_valid) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_x_raw <= xr;
    in_y_raw <= yr;
    in_z_raw <= zr;
    do @(posedge clk); while (in_stall);
    exp_res = predict_sample(act, xr, yr, zr);
    if (typed) begin
      // rows whose result is plainly all zero apart from the echoed kind
      exp_res = '0;
      exp_res.kind = act;
    end
    pending_results.push_back(exp_res);
    sent_by_kind[act]++;
    if (exp_res.cal_done) cal_completions++;
  endtask

  // Hold the sender until every expected beat is back, then let it settle
  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GYRO_CAL:  gyro_cnt_reg = val;
      REG_ACC_CAL:   acc_cnt_reg = val;
      REG_STEP_TIME: step_reg = val;
      REG_INV_ROLL:  inv_reg[0] = val;
      REG_INV_PITCH: inv_reg[1] = val;
      REG_INV_YAW:   inv_reg[2] = val;
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] gc, logic [15:0] ac, logic [15:0] st,
                           logic [15:0] ir, logic [15:0] ip, logic [15:0] iy);
    write_reg(REG_GYRO_CAL, gc);
    write_reg(REG_ACC_CAL, ac);
    write_reg(REG_STEP_TIME, st);
    write_reg(REG_INV_ROLL, ir);
    write_reg(REG_INV_PITCH, ip);
    write_reg(REG_INV_YAW, iy);
  endtask

  function automatic logic signed [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      3, 4: return 16'($signed($urandom_range(0, 256)) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] rand_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return ACT_GYRO;
    if (r < 70) return ACT_ACCEL;
    if (r < 85) return ACT_GCAL;
    return ACT_ACAL;
  endfunction

  sample_row_t directed [20] = '{
    '{ACT_GYRO,  16'sd0,      16'sd0,      16'sd0,      1'b1},
    '{ACT_ACCEL, 16'sd0,      16'sd0,      16'sd0,      1'b1},
    '{ACT_ACCEL, 16'sd0,      16'sd0,      16'sd500,    1'b1},
    '{ACT_GCAL,  16'sd0,      16'sd0,      16'sd0,      1'b1},
    '{ACT_GYRO,  16'sd32767,  -16'sd32768, 16'sd1,      1'b0},
    '{ACT_GYRO,  -16'sd32768, 16'sd32767,  -16'sd1,     1'b0},
    '{ACT_ACCEL, 16'sd0,      16'sd100,    16'sd0,      1'b0},
    '{ACT_ACCEL, -16'sd100,   16'sd0,      16'sd0,      1'b0},
    '{ACT_ACCEL, 16'sd32767,  -16'sd32768, 16'sd32767,  1'b0},
    '{ACT_ACCEL, -16'sd32768, 16'sd32767,  -16'sd32768, 1'b0},
    '{ACT_ACCEL, 16'sd4000,   -16'sd3000,  16'sd16384,  1'b0},
    '{ACT_GCAL,  16'sd32767,  16'sd32767,  16'sd32767,  1'b0},
    '{ACT_ACAL,  -16'sd32768, -16'sd32768, -16'sd32768, 1'b0},
    '{ACT_ACAL,  16'sd1,      -16'sd1,     16'sd2,      1'b0},
    '{ACT_GYRO,  16'sd1,      -16'sd1,     16'sd0,      1'b0},
    '{ACT_GYRO,  -16'sd21846, 16'sd21845,  16'sd255,    1'b0},
    '{ACT_ACCEL, 16'sd1,      16'sd1,      16'sd0,      1'b0},
    '{ACT_ACCEL, 16'sd0,      -16'sd1,     -16'sd1,     1'b0},
    '{ACT_GCAL,  -16'sd5,     16'sd7,      -16'sd9,     1'b0},
    '{ACT_ACAL,  16'sd0,      16'sd0,      16'sd0,      1'b0}
  };

  task automatic random_items(int count);
    for (int k = 0; k < count; k++)
      send_sample(rand_action(), rand_word(), rand_word(), rand_word(), 1'b0);
  endtask

  initial begin
    gyro_cnt_reg = GYRO_CAL_DEF;
    acc_cnt_reg = ACC_CAL_DEF;
    step_reg = STEP_TIME_DEF;
    inv_reg[0] = INV_ROLL_DEF;
    inv_reg[1] = INV_PITCH_DEF;
    inv_reg[2] = INV_YAW_DEF;
    for (int i = 0; i < 3; i++) begin
      gyro_off[i] = 0; acc_off[i] = 0; sums[i] = 0; angles[i] = 0;
    end
    cal_count = 0;
    tilts = '{0, 0};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[r])
      send_sample(directed[r].action, directed[r].x, directed[r].y, directed[r].z,
                  directed[r].typed);
    drain();

    // Smallest registers: count one, zero step
    write_all(16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1);
    random_items(250);
    drain();

    // Count zero acts as one; short runs with mixed kinds
    write_all(16'd0, 16'd3, 16'd1000, 16'd986, 16'd4000, 16'd1001);
    random_items(300);
    drain();

    // Largest registers: full-scale rates both ways to push the angles toward saturation
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (5) send_sample(ACT_GCAL, rand_word(), rand_word(), rand_word(), 1'b0);
    repeat (200) send_sample(ACT_GYRO, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
    repeat (300) send_sample(ACT_GYRO, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    random_items(100);
    drain();

    // Lower the count mid run: next calibration beat closes it
    write_reg(REG_GYRO_CAL, 16'd2);
    send_sample(ACT_GCAL, 16'sd300, -16'sd300, 16'sd7, 1'b0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_all(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)), 16'($urandom),
                16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                16'($urandom_range(1, 65535)));
      // mostly complete runs of one kind, then measurements against them
      for (int k = 0; k < 4; k++) begin
        repeat (acc_cnt_reg) send_sample(ACT_ACAL, rand_word(), rand_word(),
                                         rand_word(), 1'b0);
        repeat (gyro_cnt_reg) send_sample(ACT_GCAL, rand_word(), rand_word(),
                                          rand_word(), 1'b0);
        for (int m = 0; m < 30; m++)
          send_sample($urandom_range(0, 1) ? ACT_GYRO : ACT_ACCEL, rand_word(),
                      rand_word(), rand_word(), 1'b0);
      end
      random_items(60);
      drain();
    end

    drain();
    $display("sent %0d gyro, %0d accel, %0d gyro cal, %0d accel cal beats",
             sent_by_kind[ACT_GYRO], sent_by_kind[ACT_ACCEL],
             sent_by_kind[ACT_GCAL], sent_by_kind[ACT_ACAL]);
    $display("checked %0d results, %0d calibration runs closed, %0d rate clamps",
             got_results, cal_completions, rate_clamps);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+src
src/irt_pkg.sv
src/irt_axis_lane.sv
src/irt_tilt_lane.sv
src/imu_rate_integrate_and_tilt.sv
src/irt_checker.sv
tb/sv/tb.sv
